>>> rtl/core/gws_pkg.sv
// ----------------------------------------------------------------------------
// gws_pkg
// Shared types, letter codes and the progress step of the word matcher.
// ----------------------------------------------------------------------------
package gws_pkg;

    typedef logic [2:0] prog_t;
    typedef logic [7:0] char_t;

    localparam prog_t WORD_LEN    = 3'd5;
    localparam char_t CH_S        = 8'h73;
    localparam char_t CH_P        = 8'h70;
    localparam char_t CH_O        = 8'h6F;
    localparam char_t CH_N        = 8'h6E;
    localparam char_t CASE_OFFSET = 8'h20;

    // lower-case letter, or its upper-case form
    function automatic logic letter_is(input char_t ch, input char_t lower);
        return (ch == lower) || (ch == (lower - CASE_OFFSET));
    endfunction

    // new match count after one more character
    function automatic prog_t advance(input prog_t prog, input char_t ch);
        logic hit;
        case (prog)
            3'd0: hit = letter_is(ch, CH_S);
            3'd1: hit = letter_is(ch, CH_P);
            3'd2: hit = letter_is(ch, CH_O);
            3'd3: hit = letter_is(ch, CH_O);
            3'd4: hit = letter_is(ch, CH_N);
            default: hit = 1'b0;
        endcase
        if (hit) begin
            return prog + 3'd1;
        end
        return letter_is(ch, CH_S) ? 3'd1 : 3'd0;
    endfunction

endpackage

>>> rtl/core/grid_word_search.sv
// ----------------------------------------------------------------------------
// grid_word_search
// Streaming search for "spoon" (any case) along rows and columns of a grid.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  input   | s_valid s_ready s_char_code         | in
//          | s_last_of_grid                      |
//  result  | m_valid m_ready m_word_found        | out
//  config  | cfg_valid cfg_ready cfg_data        | in
//
//  One character per cycle while s_ready is high. Column progress sits in
//  a RAM with a registered read: read on accept, updated and written back
//  in the next cycle, with a bypass for a column hit again on the next
//  cycle (row length of one). m_valid rises once the last character's flag
//  has passed stage 1 into a two-entry result queue that absorbs stalls;
//  s_ready drops when queued and pending results fill both entries with no
//  pop. Reset is synchronous; the column RAM needs no clearing.
// ----------------------------------------------------------------------------
module grid_word_search #(
    parameter int MAX_COLS = 128
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_code,
    input  logic       s_last_of_grid,

    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_word_found,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int CW   = $clog2(MAX_COLS);
    localparam int CMPW = (CW + 1 > 8) ? CW + 1 : 8;

    // ---------------- configuration ----------------
    logic [7:0] row_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_length_reg <= 8'd128;
        end else if (cfg_valid) begin
            row_length_reg <= cfg_data;
        end
    end

    logic [CMPW-1:0] len_raw;
    logic [CMPW-1:0] len_eff;

    always_comb begin
        len_raw = CMPW'(row_length_reg);
        if (len_raw == '0) begin
            len_eff = CMPW'(1);
        end else if (len_raw > CMPW'(MAX_COLS)) begin
            len_eff = CMPW'(MAX_COLS);
        end else begin
            len_eff = len_raw;
        end
    end

    // ---------------- stage 0: row progress, column address ----------------
    logic           s_xfer;
    logic [CW-1:0]  col_reg,   col_next;
    gws_pkg::prog_t rp_reg,    rp_next;
    logic           first_reg, first_next;

    logic [CW-1:0]  col_cur;
    gws_pkg::prog_t rp_cur;
    gws_pkg::prog_t rp_new;
    logic           first_cur;
    logic [CMPW-1:0] col_inc;
    logic           wrap;

    assign s_xfer = s_valid && s_ready;

    always_comb begin
        // a shorter row length set mid-row starts a new row here
        wrap      = CMPW'(col_reg) >= len_eff;
        col_cur   = wrap ? '0 : col_reg;
        rp_cur    = wrap ? '0 : rp_reg;
        first_cur = wrap ? 1'b0 : first_reg;

        rp_new  = gws_pkg::advance(rp_cur, s_char_code);
        col_inc = CMPW'(col_cur) + CMPW'(1);

        if (col_inc >= len_eff) begin
            col_next   = '0;
            rp_next    = '0;
            first_next = 1'b0;
        end else begin
            col_next   = col_inc[CW-1:0];
            rp_next    = rp_new;
            first_next = first_cur;
        end
        if (s_last_of_grid) begin
            col_next   = '0;
            rp_next    = '0;
            first_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            rp_reg    <= '0;
            first_reg <= 1'b1;
        end else if (s_xfer) begin
            col_reg   <= col_next;
            rp_reg    <= rp_next;
            first_reg <= first_next;
        end
    end

    // ---------------- stage 1: column update ----------------
    logic           s1_valid_reg;
    logic [CW-1:0]  s1_col_reg;
    logic [7:0]     s1_ch_reg;
    logic           s1_first_reg;
    logic           s1_row_hit_reg;
    logic           s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            s1_col_reg     <= col_cur;
            s1_ch_reg      <= s_char_code;
            s1_first_reg   <= first_cur;
            s1_row_hit_reg <= (rp_new == gws_pkg::WORD_LEN);
            s1_last_reg    <= s_last_of_grid;
        end
    end

    gws_pkg::prog_t ram_rd_data;
    gws_pkg::prog_t vert;
    gws_pkg::prog_t prev_prog;

    gws_col_ram #(
        .DEPTH (MAX_COLS)
    ) u_col_ram (
        .aclk    (aclk),
        .rd_en   (s_xfer),
        .rd_addr (col_cur),
        .rd_data (ram_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (vert)
    );

    // last write, kept for the read that raced it
    logic           wr_valid_reg;
    logic [CW-1:0]  wr_col_reg;
    gws_pkg::prog_t wr_prog_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_valid_reg <= 1'b0;
        end else begin
            wr_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            wr_col_reg  <= s1_col_reg;
            wr_prog_reg <= vert;
        end
    end

    always_comb begin
        if (s1_first_reg) begin
            prev_prog = '0;
        end else if (wr_valid_reg && (wr_col_reg == s1_col_reg)) begin
            prev_prog = wr_prog_reg;
        end else begin
            prev_prog = ram_rd_data;
        end
        vert = gws_pkg::advance(prev_prog, s1_ch_reg);
    end

    logic seen_reg, seen_next;
    logic found;
    logic push;

    assign found = seen_reg || s1_row_hit_reg || (vert == gws_pkg::WORD_LEN);
    assign push  = s1_valid_reg && s1_last_reg;

    always_comb begin
        seen_next = seen_reg;
        if (s1_valid_reg) begin
            seen_next = s1_last_reg ? 1'b0 : found;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    // ---------------- result queue, two entries ----------------
    logic [1:0] q_cnt_reg;
    logic       q0_reg;
    logic       q1_reg;
    logic       pop;
    logic [1:0] slots;

    assign m_valid      = (q_cnt_reg != 2'd0);
    assign m_word_found = q0_reg;
    assign pop          = m_valid && m_ready;
    assign slots        = q_cnt_reg + {1'b0, push};
    assign s_ready      = (slots < 2'd2) || pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= 2'd0;
        end else begin
            case ({push, pop})
                2'b10:   q_cnt_reg <= q_cnt_reg + 2'd1;
                2'b01:   q_cnt_reg <= q_cnt_reg - 2'd1;
                default: q_cnt_reg <= q_cnt_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case ({push, pop})
            2'b11: begin
                if (q_cnt_reg == 2'd1) begin
                    q0_reg <= found;
                end else begin
                    q0_reg <= q1_reg;
                    q1_reg <= found;
                end
            end
            2'b10: begin
                if (q_cnt_reg == 2'd0) begin
                    q0_reg <= found;
                end else begin
                    q1_reg <= found;
                end
            end
            2'b01: begin
                q0_reg <= q1_reg;
            end
            default: begin
                q0_reg <= q0_reg;
            end
        endcase
    end

endmodule

>>> rtl/core/gws_col_ram.sv
// ----------------------------------------------------------------------------
// gws_col_ram
// Per-column match progress, one entry per column, registered read port.
// ----------------------------------------------------------------------------
module gws_col_ram #(
    parameter int DEPTH = 128
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    output gws_pkg::prog_t            rd_data,
    input  logic                      wr_en,
    input  logic [$clog2(DEPTH)-1:0]  wr_addr,
    input  gws_pkg::prog_t            wr_data
);

    gws_pkg::prog_t mem [DEPTH];
    gws_pkg::prog_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/gws_checker.sv
// ----------------------------------------------------------------------------
// gws_checker
// Port-level checks for grid_word_search, bound to the top level.
// ----------------------------------------------------------------------------
module gws_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_last_of_grid,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_word_found,
    input logic       cfg_ready
);

    // held result must not change while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word_found))
        else $error("result changed or dropped while stalled");

    // a last-character transfer with no result pending is followed by a valid result
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_of_grid && !m_valid |=> ##1 m_valid)
        else $error("missing found flag after last character");

    // with the result queue empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result queue");

    // no result right after reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind grid_word_search gws_checker u_gws_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_last_of_grid (s_last_of_grid),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_word_found   (m_word_found),
    .cfg_ready      (cfg_ready)
);
